// ===== sv/bcba_pkg.sv =====
// Shared types and constants for the bitmap contiguous block allocator.
// No dependencies; used by bitmap_contiguous_block_allocator and the testbench.
`default_nettype none
package bcba_pkg;

  // Default pool size in blocks
  localparam int MAX_BLOCKS_DEF = 1024;

  // Field widths
  localparam int BYTES_W  = 24;
  localparam int OFFSET_W = 26;
  localparam int BSIZE_W  = 16;
  localparam int BCOUNT_W = 11;
  localparam int CFG_IDX_W = 8;
  localparam int STATUS_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 8'd1;

  // Register reset values
  localparam logic [BSIZE_W-1:0]  BLOCK_BYTES_RST   = 16'd64;
  localparam logic [BCOUNT_W-1:0] BLOCKS_IN_USE_RST = 11'd1024;

  // Operations and status codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_RUN  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_REQ = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_SCAN_RD,
    S_SCAN_BITS,
    S_MARK_RD,
    S_MARK_WR
  } state_t;

endpackage
`default_nettype wire

// ===== sv/bcba_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none
module bcba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/bitmap_contiguous_block_allocator.sv =====
// Top level: bitmap first-fit block allocator with a usage bitmap in RAM.
// Depends on bcba_pkg and bcba_ram.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------------
//  request  | start / busy              | in_operation, in_byte_count, in_free_offset
//  result   | out_valid (1-cycle strobe)| out_status, out_alloc_offset
//  config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// Per request: a zero byte count or zero block size is answered straight from idle;
// allocate runs the divider (an oversize allocate ends there), then scans bitmap
// words (one RAM read, four 8-bit slices each), then reads and writes each word marked.
// Free runs the divider twice (bytes, then offset), then reads and writes each word cleared.
// After reset a clearing pass writes every bitmap word,
// with busy high. The result strobe cannot be stalled; busy drops with it.
`default_nettype none
module bitmap_contiguous_block_allocator #(
  parameter int MAX_BLOCKS = bcba_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               in_operation,
  input  wire logic [bcba_pkg::BYTES_W-1:0]       in_byte_count,
  input  wire logic [bcba_pkg::OFFSET_W-1:0]      in_free_offset,
  output logic                                    out_valid,
  output logic [bcba_pkg::STATUS_W-1:0]           out_status,
  output logic [bcba_pkg::OFFSET_W-1:0]           out_alloc_offset,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [bcba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bcba_pkg::BSIZE_W-1:0]       cfg_data
);

  localparam int WORDS = (MAX_BLOCKS + 31) / 32;
  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BW = $clog2(MAX_BLOCKS + 1);
  localparam int DIV_STEPS = bcba_pkg::OFFSET_W;
  localparam int DCW = $clog2(DIV_STEPS);
  localparam int SW = bcba_pkg::BSIZE_W;

  // Registers
  bcba_pkg::state_t state_r, state_nxt;
  logic [SW-1:0]                     bb_r, bb_nxt;
  logic [bcba_pkg::BCOUNT_W-1:0]     biu_r, biu_nxt;
  logic                              op_r, op_nxt;
  logic [bcba_pkg::OFFSET_W-1:0]     off_r, off_nxt;
  logic [BW-1:0]                     cnt_r, cnt_nxt;
  logic [DCW-1:0]                    dstep_r, dstep_nxt;
  logic                              dsel_r, dsel_nxt;   // 0 block count, 1 start block
  logic [SW-1:0]                     rem_r, rem_nxt;
  logic [bcba_pkg::OFFSET_W-1:0]     quo_r, quo_nxt;
  logic [bcba_pkg::BYTES_W:0]        nfree_r, nfree_nxt;
  logic [BW-1:0]                     need_r, need_nxt;
  logic [AW-1:0]                     w_r, w_nxt;
  logic [1:0]                        sub_r, sub_nxt;
  logic [BW-1:0]                     run_r, run_nxt;
  logic [BW-1:0]                     lo_r, lo_nxt;
  logic [BW-1:0]                     hi_r, hi_nxt;
  logic                              set_r, set_nxt;
  logic                              ov_r, ov_nxt;
  logic [bcba_pkg::STATUS_W-1:0]     os_r, os_nxt;
  logic [bcba_pkg::OFFSET_W-1:0]     oo_r, oo_nxt;

  // RAM port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [31:0]   ram_wd, ram_rd;

  bcba_ram #(.WIDTH(32), .DEPTH(WORDS)) u_map (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  // Effective block count from the register
  logic [BW-1:0] cnt_eff;
  assign cnt_eff = (32'(biu_r) < 32'(MAX_BLOCKS)) ? BW'(biu_r) : BW'(MAX_BLOCKS);

  // Divider step: one quotient bit per cycle
  logic [SW:0]                   rem_sh;
  logic                          qbit;
  logic [SW-1:0]                 rem_new;
  logic [bcba_pkg::OFFSET_W-1:0] quo_new;
  logic                          div_last;
  logic [bcba_pkg::BYTES_W:0]    need_full;
  always_comb begin
    rem_sh   = {rem_r, quo_r[bcba_pkg::OFFSET_W-1]};
    qbit     = rem_sh >= {1'b0, bb_r};
    rem_new  = qbit ? SW'(rem_sh - {1'b0, bb_r}) : rem_sh[SW-1:0];
    quo_new  = {quo_r[bcba_pkg::OFFSET_W-2:0], qbit};
    div_last = (dstep_r == DCW'(DIV_STEPS - 1));
    need_full = {1'b0, quo_new[bcba_pkg::BYTES_W-1:0]} + (bcba_pkg::BYTES_W + 1)'(1);
  end

  // Free range: start block and clipped end
  logic                       first_out;
  logic [bcba_pkg::OFFSET_W:0] free_end;
  logic [BW-1:0]              free_hi;
  always_comb begin
    first_out = (32'(quo_new) >= 32'(cnt_r));
    free_end  = {1'b0, quo_new} + (bcba_pkg::OFFSET_W + 1)'(nfree_r);
    free_hi   = (32'(free_end) < 32'(cnt_r)) ? BW'(free_end) : cnt_r;
  end

  // Scan of one 8-bit slice of the current word
  logic          sc_found;
  logic [BW-1:0] sc_start;
  logic [BW-1:0] sc_run;
  logic          sc_word_end;
  always_comb begin
    logic [31:0] pos;
    logic [31:0] run_v;
    sc_found = 1'b0;
    sc_start = '0;
    run_v    = 32'(run_r);
    for (int j = 0; j < 8; j++) begin
      pos = (32'(w_r) << 5) + (32'(sub_r) << 3) + 32'(j);
      if (!sc_found && pos < 32'(cnt_r)) begin
        if (ram_rd[{sub_r, 3'(j)}]) begin
          run_v = '0;
        end else begin
          run_v = run_v + 32'd1;
          if (run_v == 32'(need_r)) begin
            sc_found = 1'b1;
            sc_start = BW'(pos + 32'd1 - 32'(need_r));
          end
        end
      end
    end
    sc_run      = BW'(run_v);
    sc_word_end = ((32'(w_r) + 32'd1) << 5) >= 32'(cnt_r);
  end

  // Word update for marking or clearing a block range
  logic [31:0] mark_word;
  logic        mark_last;
  always_comb begin
    logic [31:0] pos;
    for (int b = 0; b < 32; b++) begin
      pos = (32'(w_r) << 5) + 32'(b);
      if (pos >= 32'(lo_r) && pos < 32'(hi_r)) begin
        mark_word[b] = set_r;
      end else begin
        mark_word[b] = ram_rd[b];
      end
    end
    mark_last = ((32'(w_r) + 32'd1) << 5) >= 32'(hi_r);
  end

  logic in_bad;
  assign in_bad = (bb_r == '0) || (in_byte_count == '0);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bcba_pkg::S_CLEAR: begin
        if (w_r == AW'(WORDS - 1)) state_nxt = bcba_pkg::S_IDLE;
      end
      bcba_pkg::S_IDLE: begin
        if (start && !in_bad) state_nxt = bcba_pkg::S_DIV;
      end
      bcba_pkg::S_DIV: begin
        if (div_last) begin
          if (op_r == bcba_pkg::OP_ALLOC) begin
            state_nxt = (32'(need_full) > 32'(cnt_r)) ? bcba_pkg::S_IDLE
                                                      : bcba_pkg::S_SCAN_RD;
          end else if (dsel_r) begin
            state_nxt = first_out ? bcba_pkg::S_IDLE : bcba_pkg::S_MARK_RD;
          end
        end
      end
      bcba_pkg::S_SCAN_RD: state_nxt = bcba_pkg::S_SCAN_BITS;
      bcba_pkg::S_SCAN_BITS: begin
        if (sc_found) begin
          state_nxt = bcba_pkg::S_MARK_RD;
        end else if (sub_r == 2'd3) begin
          state_nxt = sc_word_end ? bcba_pkg::S_IDLE : bcba_pkg::S_SCAN_RD;
        end
      end
      bcba_pkg::S_MARK_RD: state_nxt = bcba_pkg::S_MARK_WR;
      bcba_pkg::S_MARK_WR: begin
        state_nxt = mark_last ? bcba_pkg::S_IDLE : bcba_pkg::S_MARK_RD;
      end
      default: state_nxt = bcba_pkg::S_IDLE;
    endcase
  end

  // Datapath, RAM control and result
  always_comb begin
    bb_nxt = bb_r;  biu_nxt = biu_r;
    op_nxt = op_r;  off_nxt = off_r;  cnt_nxt = cnt_r;
    dstep_nxt = dstep_r;  dsel_nxt = dsel_r;
    rem_nxt = rem_r;  quo_nxt = quo_r;  nfree_nxt = nfree_r;  need_nxt = need_r;
    w_nxt = w_r;  sub_nxt = sub_r;  run_nxt = run_r;
    lo_nxt = lo_r;  hi_nxt = hi_r;  set_nxt = set_r;
    ov_nxt = 1'b0;  os_nxt = os_r;  oo_nxt = oo_r;
    ram_we = 1'b0;  ram_wa = w_r;  ram_wd = '0;
    ram_re = 1'b0;  ram_ra = w_r;

    // Configuration writes
    if (cfg_valid) begin
      if (cfg_index == bcba_pkg::REG_BLOCK_BYTES) bb_nxt = cfg_data;
      else if (cfg_index == bcba_pkg::REG_BLOCKS_IN_USE)
        biu_nxt = cfg_data[bcba_pkg::BCOUNT_W-1:0];
    end

    case (state_r)
      bcba_pkg::S_CLEAR: begin
        ram_we = 1'b1;
        w_nxt  = (w_r == AW'(WORDS - 1)) ? '0 : w_r + AW'(1);
      end
      bcba_pkg::S_IDLE: begin
        if (start) begin
          op_nxt  = in_operation;
          off_nxt = in_free_offset;
          cnt_nxt = cnt_eff;
          if (in_bad) begin
            ov_nxt = 1'b1;
            oo_nxt = '0;
            os_nxt = (in_operation == bcba_pkg::OP_ALLOC) ? bcba_pkg::ST_BAD_REQ
                                                          : bcba_pkg::ST_OK;
          end else begin
            dstep_nxt = '0;
            dsel_nxt  = 1'b0;
            rem_nxt   = '0;
            quo_nxt   = bcba_pkg::OFFSET_W'(in_byte_count - bcba_pkg::BYTES_W'(1));
          end
        end
      end
      bcba_pkg::S_DIV: begin
        rem_nxt   = rem_new;
        quo_nxt   = quo_new;
        dstep_nxt = dstep_r + DCW'(1);
        if (div_last) begin
          if (op_r == bcba_pkg::OP_ALLOC) begin
            need_nxt = BW'(need_full);
            w_nxt    = '0;
            sub_nxt  = '0;
            run_nxt  = '0;
            set_nxt  = 1'b1;
            if (32'(need_full) > 32'(cnt_r)) begin
              ov_nxt = 1'b1;
              os_nxt = bcba_pkg::ST_BAD_REQ;
              oo_nxt = '0;
            end
          end else if (!dsel_r) begin
            // second pass divides the offset
            nfree_nxt = need_full;
            dsel_nxt  = 1'b1;
            dstep_nxt = '0;
            rem_nxt   = '0;
            quo_nxt   = off_r;
          end else begin
            set_nxt = 1'b0;
            lo_nxt  = BW'(quo_new);
            hi_nxt  = free_hi;
            w_nxt   = AW'(32'(quo_new) >> 5);
            if (first_out) begin
              ov_nxt = 1'b1;
              os_nxt = bcba_pkg::ST_OK;
              oo_nxt = '0;
            end
          end
        end
      end
      bcba_pkg::S_SCAN_RD: begin
        ram_re = 1'b1;
      end
      bcba_pkg::S_SCAN_BITS: begin
        run_nxt = sc_run;
        sub_nxt = sub_r + 2'd1;
        if (sc_found) begin
          lo_nxt = sc_start;
          hi_nxt = sc_start + need_r;
          w_nxt  = AW'(32'(sc_start) >> 5);
        end else if (sub_r == 2'd3) begin
          w_nxt = w_r + AW'(1);
          if (sc_word_end) begin
            ov_nxt = 1'b1;
            os_nxt = bcba_pkg::ST_NO_RUN;
            oo_nxt = '0;
          end
        end
      end
      bcba_pkg::S_MARK_RD: begin
        ram_re = 1'b1;
      end
      bcba_pkg::S_MARK_WR: begin
        ram_we = 1'b1;
        ram_wd = mark_word;
        w_nxt  = w_r + AW'(1);
        if (mark_last) begin
          ov_nxt = 1'b1;
          os_nxt = bcba_pkg::ST_OK;
          oo_nxt = set_r ? bcba_pkg::OFFSET_W'(32'(lo_r) * 32'(bb_r)) : '0;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcba_pkg::S_CLEAR;
      bb_r    <= bcba_pkg::BLOCK_BYTES_RST;
      biu_r   <= bcba_pkg::BLOCKS_IN_USE_RST;
      w_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bb_r    <= bb_nxt;
      biu_r   <= biu_nxt;
      w_r     <= w_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    off_r   <= off_nxt;
    cnt_r   <= cnt_nxt;
    dstep_r <= dstep_nxt;
    dsel_r  <= dsel_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    nfree_r <= nfree_nxt;
    need_r  <= need_nxt;
    sub_r   <= sub_nxt;
    run_r   <= run_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    set_r   <= set_nxt;
    os_r    <= os_nxt;
    oo_r    <= oo_nxt;
  end

  assign busy             = (state_r != bcba_pkg::S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = ov_r;
  assign out_status       = os_r;
  assign out_alloc_offset = oo_r;

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for bitmap_contiguous_block_allocator.
// Depends on bcba_pkg and the allocator RTL. It predicts every result from its own
// usage bitmap and compares the results in order.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BYTES_W   = bcba_pkg::BYTES_W;
  localparam int OFFSET_W  = bcba_pkg::OFFSET_W;
  localparam int BSIZE_W   = bcba_pkg::BSIZE_W;
  localparam int BCOUNT_W  = bcba_pkg::BCOUNT_W;
  localparam int CFG_IDX_W = bcba_pkg::CFG_IDX_W;
  localparam int STATUS_W  = bcba_pkg::STATUS_W;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES   = bcba_pkg::REG_BLOCK_BYTES;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = bcba_pkg::REG_BLOCKS_IN_USE;
  localparam logic OP_ALLOC = bcba_pkg::OP_ALLOC;
  localparam logic OP_FREE  = bcba_pkg::OP_FREE;
  localparam logic [STATUS_W-1:0] ST_OK      = bcba_pkg::ST_OK;
  localparam logic [STATUS_W-1:0] ST_NO_RUN  = bcba_pkg::ST_NO_RUN;
  localparam logic [STATUS_W-1:0] ST_BAD_REQ = bcba_pkg::ST_BAD_REQ;

  localparam int MAP_BLOCKS = bcba_pkg::MAX_BLOCKS_DEF;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 400;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 8'hFF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] offset;
  } alloc_result_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [BYTES_W-1:0]  bytes;
  } region_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_operation = OP_ALLOC;
  logic [BYTES_W-1:0] in_byte_count = '0;
  logic [OFFSET_W-1:0] in_free_offset = '0;
  logic out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [OFFSET_W-1:0] out_alloc_offset;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BSIZE_W-1:0] cfg_data = '0;

  bitmap_contiguous_block_allocator u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_byte_count(in_byte_count),
    .in_free_offset(in_free_offset), .out_valid(out_valid),
    .out_status(out_status), .out_alloc_offset(out_alloc_offset),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Allocator state as the testbench sees it
  logic [BSIZE_W-1:0]  pool_block_bytes;
  logic [BCOUNT_W-1:0] pool_blocks;
  bit                  used_map [MAP_BLOCKS];
  alloc_result_t       pending_results[$];
  region_t             live_regions[$];
  int                  idle_pct = 0;
  int                  fail_count = 0;
  int                  cycle_count = 0;

  function automatic int unsigned managed_blocks();
    return (pool_blocks < MAP_BLOCKS) ? pool_blocks : MAP_BLOCKS;
  endfunction

  function automatic alloc_result_t predict_request(logic op, logic [BYTES_W-1:0] bytes,
                                                    logic [OFFSET_W-1:0] offs);
    alloc_result_t res;
    int unsigned count, need, run, first, found_at, i;
    bit found;
    longint unsigned prod;
    res = '{status: ST_OK, offset: '0};
    count = managed_blocks();
    if (op == OP_ALLOC) begin
      if (pool_block_bytes == 0 || bytes == 0) begin
        res.status = ST_BAD_REQ;
      end else begin
        need = (bytes - 1) / pool_block_bytes + 1;
        if (need > count) begin
          res.status = ST_BAD_REQ;
        end else begin
          // first fit: lowest run of need free blocks
          run = 0;
          found = 0;
          found_at = 0;
          for (i = 0; i < count && !found; i++) begin
            if (used_map[i]) run = 0;
            else begin
              run++;
              if (run == need) begin
                found = 1;
                found_at = i + 1 - need;
              end
            end
          end
          if (found) begin
            for (i = 0; i < need; i++) used_map[found_at + i] = 1;
            prod = longint'(found_at) * pool_block_bytes;
            res.offset = prod[OFFSET_W-1:0];
          end else begin
            res.status = ST_NO_RUN;
          end
        end
      end
    end else if (pool_block_bytes != 0 && bytes != 0) begin
      // free clips the range at the managed block count
      first = offs / pool_block_bytes;
      need = (bytes - 1) / pool_block_bytes + 1;
      for (i = 0; i < need && first < count && i < count - first; i++)
        used_map[first + i] = 0;
    end
    return res;
  endfunction

  // Drive one request and hold it until accepted; start stays high afterward
  task automatic send_request(logic op, logic [BYTES_W-1:0] bytes,
                              logic [OFFSET_W-1:0] offs, output alloc_result_t res);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_byte_count <= bytes;
    in_free_offset <= offs;
    do @(posedge clk); while (busy);
    res = predict_request(op, bytes, offs);
    pending_results.push_back(res);
  endtask

  task automatic send(logic op, logic [BYTES_W-1:0] bytes, logic [OFFSET_W-1:0] offs);
    alloc_result_t res;
    send_request(op, bytes, offs, res);
  endtask

  // Stop sending and wait until every outstanding transaction has returned
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Register write; cfg_valid stays high unless this is the last of a group
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [BSIZE_W-1:0] data, bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_BLOCK_BYTES) pool_block_bytes = data;
    else if (idx == REG_BLOCKS_IN_USE) pool_blocks = data[BCOUNT_W-1:0];
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [BSIZE_W-1:0] bb, logic [BSIZE_W-1:0] nblocks);
    drain();
    cfg_write(REG_BLOCK_BYTES, bb, 0);
    cfg_write(REG_BLOCKS_IN_USE, nblocks, 1);
  endtask

  // Result checker
  always @(posedge clk) begin
    alloc_result_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d offset %0d", out_status, out_alloc_offset);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, out_status);
          fail_count++;
        end
        if (out_alloc_offset !== exp_res.offset) begin
          $error("alloc_offset: expected %0d, got %0d", exp_res.offset, out_alloc_offset);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Field extremes and special cases at the reset configuration
  task automatic test_directed();
    send(OP_ALLOC, '0, '0);                 // zero size
    send(OP_ALLOC, 24'd1, '1);              // one block, offset ignored
    send(OP_ALLOC, 24'd64, '0);             // exactly one block
    send(OP_ALLOC, 24'd65, '0);             // rounds up to two
    send(OP_ALLOC, '1, '0);                 // oversize
    send(OP_ALLOC, 24'd65536, '0);          // whole pool, no run left
    send(OP_FREE, 24'd64, 26'd64);          // hole at block 1
    send(OP_FREE, 24'd64, 26'd64);          // already free
    send(OP_ALLOC, 24'd64, '0);             // refills the hole
    send(OP_FREE, '0, '0);                  // zero count frees nothing
    send(OP_FREE, '1, '1);                  // past the pool, ignored
    send(OP_FREE, '1, '0);                  // free all
    send(OP_ALLOC, 24'd65536, '0);          // whole pool
    send(OP_ALLOC, 24'd1, '0);              // no run
    send(OP_FREE, 24'd128, 26'd65471);      // unaligned offset rounds down
    send(OP_ALLOC, 24'd100, '0);
    send(OP_FREE, '1, '0);
  endtask

  // Register extremes, the unused index and data bits past the register width
  task automatic test_config_extremes();
    configure('0, 16'd1024);                // zero block size
    send(OP_ALLOC, 24'd1, '0);
    send(OP_FREE, '1, '0);
    configure(16'd1, '0);                   // zero blocks
    send(OP_ALLOC, 24'd1, '0);
    send(OP_FREE, 24'd1, '0);
    configure(16'd1, 16'd1);                // single block
    send(OP_ALLOC, 24'd1, '0);
    send(OP_ALLOC, 24'd1, '0);
    send(OP_ALLOC, 24'd2, '0);
    send(OP_FREE, 24'd1, '0);
    drain();
    cfg_write(REG_UNUSED, '1, 0);
    cfg_write(REG_TOP, '1, 0);
    cfg_write(REG_BLOCKS_IN_USE, '1, 0);    // masks to 2047, clipped to the pool
    cfg_write(REG_BLOCK_BYTES, '1, 1);
    send(OP_FREE, '1, '0);
    send(OP_ALLOC, 24'd196605, '0);         // three blocks of 65535 bytes
    send(OP_ALLOC, 24'd65536, '0);
    send(OP_FREE, '1, '0);
  endtask

  // Random traffic: mostly allocate/free pairs, some partial frees and noise
  task automatic test_random(int items, logic [BSIZE_W-1:0] bb, logic [BSIZE_W-1:0] nblocks);
    alloc_result_t res;
    int unsigned r, nb, k;
    longint unsigned bytes;
    configure(bb, nblocks);
    live_regions.delete();
    send(OP_FREE, '1, '0);
    for (int n = 0; n < items; n++) begin
      r = $urandom_range(99);
      if ($urandom_range(49) == 0) drain();  // let the pipeline run dry
      if (r < 50) begin
        nb = ($urandom_range(19) == 0) ? $urandom_range(1, managed_blocks() + 1)
                                       : $urandom_range(1, 8);
        bytes = longint'(nb - 1) * bb + $urandom_range(1, (bb == 0) ? 1 : bb);
        if (bytes > 24'hFFFFFF) bytes = 24'hFFFFFF;
        send_request(OP_ALLOC, bytes[BYTES_W-1:0], OFFSET_W'($urandom), res);
        if (res.status == ST_OK) live_regions.push_back('{res.offset, bytes[BYTES_W-1:0]});
      end else if (r < 85 && live_regions.size() != 0) begin
        k = $urandom_range(live_regions.size() - 1);
        send(OP_FREE, live_regions[k].bytes, live_regions[k].offset);
        live_regions.delete(k);
      end else if (r < 92) begin
        bytes = longint'(managed_blocks() + 2) * bb;
        send(OP_FREE, BYTES_W'($urandom_range(1, 3 * bb)),
             OFFSET_W'((bytes > 26'h3FFFFFF) ? $urandom : $urandom_range(0, 32'(bytes))));
      end else begin
        send(1'($urandom_range(1)), ($urandom_range(3) == 0) ? '0 : BYTES_W'($urandom),
             OFFSET_W'($urandom));
      end
    end
  endtask

  initial begin
    pool_block_bytes = bcba_pkg::BLOCK_BYTES_RST;
    pool_blocks = bcba_pkg::BLOCKS_IN_USE_RST;
    foreach (used_map[i]) used_map[i] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct = 32;
    test_directed();
    test_config_extremes();
    test_random(180, 16'd64, 16'd1024);
    test_random(180, 16'd1, 16'd40);
    idle_pct = 55;
    test_random(180, 16'd65535, 16'd1024);
    test_random(180, 16'd24, 16'd7);
    idle_pct = 0;
    test_random(180, 16'd3, 16'd2047);
    test_random(180, 16'd1000, 16'd128);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
sv/bcba_pkg.sv
sv/bcba_ram.sv
sv/bitmap_contiguous_block_allocator.sv
sim/tb.sv
